// File: hw/rtl/bswr_pkg.sv
// bswr_pkg: shared types, constants and register codes of the bright spot window reducer
// no dependencies; used by bswr_pixel_calc, the core and the bench
package bswr_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_RADIUS = 7;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int ADDR_W = COL_W + ROW_W;

   localparam int PIX_W      = 8;
   localparam int DIM_W      = 9;
   localparam int RAD_W      = 3;
   localparam int BG_W       = 16;
   localparam int CNT_W      = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // fixed point reduce arithmetic
   localparam int PROD_W      = 27;
   localparam int NUM_W       = 28;
   localparam int BGX_W       = 23;
   localparam int QN_W        = 15;
   localparam int RCP_PROD_W  = 28;
   localparam int BG_SCALE    = 100;
   localparam int SAT_NUM     = 256 * 25600;
   localparam int RECIP_MUL   = 5243;
   localparam int RECIP_SHIFT = 19;

   // operation codes
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_READ   = 2'd1;
   localparam logic [1:0] OP_REDUCE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SPOT_BRIGHTNESS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REDUCTION_LEVEL  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPOT_RADIUS      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPOT_COUNT       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BACKGROUND_LEVEL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT     = 3'd6;

   // register reset values
   localparam logic [PIX_W-1:0] RST_SPOT_BRIGHTNESS  = 8'd220;
   localparam logic [PIX_W-1:0] RST_REDUCTION_LEVEL  = 8'd75;
   localparam logic [RAD_W-1:0] RST_SPOT_RADIUS      = 3'd4;
   localparam logic [CNT_W-1:0] RST_SPOT_COUNT       = 8'd6;
   localparam logic [BG_W-1:0]  RST_BACKGROUND_LEVEL = 16'd0;
   localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH      = 9'd256;
   localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT     = 9'd256;

   typedef struct packed {
      logic [1:0]       operation;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic [PIX_W-1:0] pixel_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             reduced;
      logic [CNT_W-1:0] bright_count;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] addr;
      logic [PIX_W-1:0]  data;
   } mem_xfer_type;

   typedef struct packed {
      logic [PIX_W-1:0] level;
      logic [BG_W-1:0]  bg;
   } calc_cfg_type;

endpackage

// File: hw/rtl/bswr_frame_ram.sv
// bswr_frame_ram: simple dual port frame memory, one write and one registered read a cycle
// generic, no package dependency
module bswr_frame_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);
   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/bswr_pixel_calc.sv
// bswr_pixel_calc: three stage pipeline for (p - bg) * level / 100 + bg, truncated and clamped
// depends on bswr_pkg
module bswr_pixel_calc (
   input  logic                   clock,
   input  logic                   reset,
   input  bswr_pkg::calc_cfg_type cfg,
   input  bswr_pkg::mem_xfer_type src,
   output bswr_pkg::mem_xfer_type dst,
   output logic                   busy
);
   import bswr_pkg::*;

   logic signed [17:0]       diff;
   logic signed [PROD_W-1:0] s1_prod_in;
   logic signed [NUM_W-1:0]  num;
   logic [BGX_W-1:0]         bg_x100;

   logic                     s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic [ADDR_W-1:0]        s1_addr_ff, s2_addr_ff, s3_addr_ff;
   logic signed [PROD_W-1:0] s1_prod_ff;
   logic                     s2_zero_ff, s2_sat_ff, s3_zero_ff, s3_sat_ff;
   logic [QN_W-1:0]          s2_n_ff;
   logic [RCP_PROD_W-1:0]    s3_prod_ff;

   // stage 1: deviation times level
   assign diff       = $signed({2'b00, src.data, 8'h00}) - $signed({2'b00, cfg.bg});
   assign s1_prod_in = diff * $signed({1'b0, cfg.level});

   // stage 2: add background, split into zero, saturate or quotient input
   assign bg_x100 = BGX_W'(cfg.bg) * BGX_W'(BG_SCALE);
   assign num     = $signed({s1_prod_ff[PROD_W-1], s1_prod_ff})
                  + $signed({{(NUM_W-BGX_W){1'b0}}, bg_x100});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= src.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      s1_addr_ff <= src.addr;
      s1_prod_ff <= s1_prod_in;
      s2_addr_ff <= s1_addr_ff;
      s2_zero_ff <= (num <= $signed(NUM_W'(0)));
      s2_sat_ff  <= (num >= $signed(NUM_W'(SAT_NUM)));
      s2_n_ff    <= num[QN_W+7:8];
      // stage 3: divide by 100 through the reciprocal
      s3_addr_ff <= s2_addr_ff;
      s3_zero_ff <= s2_zero_ff;
      s3_sat_ff  <= s2_sat_ff;
      s3_prod_ff <= RCP_PROD_W'(s2_n_ff) * RCP_PROD_W'(RECIP_MUL);
   end

   always_comb begin
      dst.valid = s3_valid_ff;
      dst.addr  = s3_addr_ff;
      if (s3_sat_ff) begin
         dst.data = '1;
      end else if (s3_zero_ff) begin
         dst.data = '0;
      end else begin
         dst.data = s3_prod_ff[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
      end
   end

   assign busy = s1_valid_ff | s2_valid_ff | s3_valid_ff;

endmodule

// File: hw/rtl/bright_spot_window_reducer_core.sv
// bright_spot_window_reducer_core: frame store with pixel write, pixel read and spot reduction
// depends on bswr_pkg, bswr_frame_ram and bswr_pixel_calc
// a reduce counts over the N in-image window pixels (up to 225 at radius 7) and
// rewrites them in a second pass when the bright count is below the spot count
// throughput: one item at a time, next start taken in the cycle the result strobe shows
// reset: synchronous, clears control state and registers; frame memory holds no reset value
module bright_spot_window_reducer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  bswr_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output bswr_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_we,
   input  logic [bswr_pkg::CSR_IDX_W-1:0]       csr_addr,
   input  logic [bswr_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import bswr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_RDWAIT,
      S_SCAN,
      S_SCAN_END,
      S_DECIDE,
      S_REWRITE,
      S_DRAIN
   } state_type;

   // configuration registers
   logic [PIX_W-1:0] thr_ff, level_ff;
   logic [RAD_W-1:0] radius_ff;
   logic [CNT_W-1:0] spot_count_ff;
   logic [BG_W-1:0]  bg_ff;
   logic [DIM_W-1:0] img_w_ff, img_h_ff;

   state_type        state_ff, state_in;
   req_type          item_ff, item_in;
   logic             inside_ff, inside_in;
   logic [COL_W-1:0] x_lo_ff, x_lo_in, x_ff, x_in;
   logic [ROW_W-1:0] y_lo_ff, y_lo_in, y_ff, y_in;
   logic [DIM_W-1:0] x_end_ff, x_end_in, y_end_ff, y_end_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rd_scan_ff, rd_scan_in, rd_fix_ff, rd_fix_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic [DIM_W-1:0] eff_w, eff_h, x_top, y_top, x_end_c, y_end_c;
   logic [RAD_W-1:0] rad;
   logic [COL_W-1:0] x_lo_c;
   logic [ROW_W-1:0] y_lo_c;
   logic             inside_c, win_empty, x_last, y_last;
   logic [COL_W-1:0] x_next;
   logic [ROW_W-1:0] y_next;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [PIX_W-1:0]  ram_wdata, ram_rdata;

   calc_cfg_type calc_cfg;
   mem_xfer_type calc_src, calc_dst;
   logic         calc_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= RST_SPOT_BRIGHTNESS;
         level_ff      <= RST_REDUCTION_LEVEL;
         radius_ff     <= RST_SPOT_RADIUS;
         spot_count_ff <= RST_SPOT_COUNT;
         bg_ff         <= RST_BACKGROUND_LEVEL;
         img_w_ff      <= RST_IMAGE_WIDTH;
         img_h_ff      <= RST_IMAGE_HEIGHT;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SPOT_BRIGHTNESS:  thr_ff        <= csr_wdata[PIX_W-1:0];
            CSR_REDUCTION_LEVEL:  level_ff      <= csr_wdata[PIX_W-1:0];
            CSR_SPOT_RADIUS:      radius_ff     <= csr_wdata[RAD_W-1:0];
            CSR_SPOT_COUNT:       spot_count_ff <= csr_wdata[CNT_W-1:0];
            CSR_BACKGROUND_LEVEL: bg_ff         <= csr_wdata[BG_W-1:0];
            CSR_IMAGE_WIDTH:      img_w_ff      <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:     img_h_ff      <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   // window bounds clipped to the image in use
   always_comb begin
      eff_w    = (img_w_ff > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : img_w_ff;
      eff_h    = (img_h_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : img_h_ff;
      rad      = (radius_ff > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_ff;
      x_lo_c   = (item_ff.col >= COL_W'(rad)) ? item_ff.col - COL_W'(rad) : '0;
      y_lo_c   = (item_ff.row >= ROW_W'(rad)) ? item_ff.row - ROW_W'(rad) : '0;
      x_top    = DIM_W'(item_ff.col) + DIM_W'(rad) + DIM_W'(1);
      y_top    = DIM_W'(item_ff.row) + DIM_W'(rad) + DIM_W'(1);
      x_end_c  = (x_top < eff_w) ? x_top : eff_w;
      y_end_c  = (y_top < eff_h) ? y_top : eff_h;
      win_empty = (DIM_W'(x_lo_c) >= x_end_c) || (DIM_W'(y_lo_c) >= y_end_c);
      inside_c = (DIM_W'(item_ff.col) < eff_w) && (DIM_W'(item_ff.row) < eff_h);
      x_last   = (DIM_W'(x_ff) + DIM_W'(1)) == x_end_ff;
      y_last   = (DIM_W'(y_ff) + DIM_W'(1)) == y_end_ff;
      x_next   = x_last ? x_lo_ff : x_ff + COL_W'(1);
      y_next   = x_last ? y_ff + ROW_W'(1) : y_ff;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      inside_in    = inside_ff;
      x_lo_in      = x_lo_ff;
      y_lo_in      = y_lo_ff;
      x_end_in     = x_end_ff;
      y_end_in     = y_end_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      count_in     = count_ff;
      rd_scan_in   = 1'b0;
      rd_fix_in    = 1'b0;
      rd_addr_in   = {y_ff, x_ff};
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ram_raddr    = {y_ff, x_ff};

      if (rd_scan_ff && (ram_rdata >= thr_ff) && (count_ff != '1)) begin
         count_in = count_ff + CNT_W'(1);
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               item_in  = req_data;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            inside_in = inside_c;
            x_lo_in   = x_lo_c;
            y_lo_in   = y_lo_c;
            x_end_in  = x_end_c;
            y_end_in  = y_end_c;
            x_in      = x_lo_c;
            y_in      = y_lo_c;
            count_in  = '0;
            ram_raddr = {item_ff.row, item_ff.col};
            case (item_ff.operation)
               OP_READ: begin
                  state_in = S_RDWAIT;
               end
               OP_REDUCE: begin
                  if (win_empty) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = '{pixel_out: '0, reduced: (spot_count_ff != '0),
                                      bright_count: '0};
                     state_in     = S_IDLE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               default: begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
                  state_in     = S_IDLE;
               end
            endcase
         end
         S_RDWAIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = '{pixel_out: (inside_ff ? ram_rdata : '0), reduced: 1'b0,
                             bright_count: '0};
            state_in     = S_IDLE;
         end
         S_SCAN: begin
            rd_scan_in = 1'b1;
            x_in       = x_next;
            y_in       = y_next;
            if (x_last && y_last) begin
               state_in = S_SCAN_END;
            end
         end
         S_SCAN_END: begin
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (count_ff < spot_count_ff) begin
               x_in     = x_lo_ff;
               y_in     = y_lo_ff;
               state_in = S_REWRITE;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{pixel_out: '0, reduced: 1'b0, bright_count: count_ff};
               state_in     = S_IDLE;
            end
         end
         S_REWRITE: begin
            rd_fix_in = 1'b1;
            x_in      = x_next;
            y_in      = y_next;
            if (x_last && y_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!rd_fix_ff && !calc_busy) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{pixel_out: '0, reduced: 1'b1, bright_count: count_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_scan_ff   <= 1'b0;
         rd_fix_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_scan_ff   <= rd_scan_in;
         rd_fix_ff    <= rd_fix_in;
      end
      item_ff     <= item_in;
      inside_ff   <= inside_in;
      x_lo_ff     <= x_lo_in;
      y_lo_ff     <= y_lo_in;
      x_end_ff    <= x_end_in;
      y_end_ff    <= y_end_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      count_ff    <= count_in;
      rd_addr_ff  <= rd_addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // write port: pixel write transfer or rewritten window pixel
   always_comb begin
      ram_we    = calc_dst.valid ||
                  ((state_ff == S_DECODE) && (item_ff.operation == OP_WRITE) && inside_c);
      ram_waddr = calc_dst.valid ? calc_dst.addr : {item_ff.row, item_ff.col};
      ram_wdata = calc_dst.valid ? calc_dst.data : item_ff.pixel_in;
   end

   bswr_frame_ram #(
      .ADDR_W (ADDR_W),
      .DATA_W (PIX_W)
   ) u_frame_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign calc_cfg = '{level: level_ff, bg: bg_ff};
   assign calc_src = '{valid: rd_fix_ff, addr: rd_addr_ff, data: ram_rdata};

   bswr_pixel_calc u_pixel_calc (
      .clock (clock),
      .reset (reset),
      .cfg   (calc_cfg),
      .src   (calc_src),
      .dst   (calc_dst),
      .busy  (calc_busy)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without an item in progress");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_SCAN_END || state_ff == S_DECIDE) |-> !ram_we)
      else $error("frame write while counting bright pixels");

   a_calc_in_rewrite: assert property (@(posedge clock) disable iff (reset)
      calc_dst.valid |-> (state_ff == S_REWRITE || state_ff == S_DRAIN))
      else $error("rewritten pixel outside the rewrite pass");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transfer did not start work");
`endif

endmodule

// File: bench/bright_spot_window_reducer_core_test.sv
`timescale 1ns / 100ps
// self-checking bench for bright_spot_window_reducer_core: pixel writes, reads and spot
// reductions checked against a frame model kept here; needs bswr_pkg and the core rtl
module bright_spot_window_reducer_core_test;
   import bswr_pkg::*;

   localparam logic [1:0]           OP_UNUSED    = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED   = 3'd7;
   localparam int                   CYCLE_LIMIT  = 2500000;
   localparam int                   DRAIN_CYCLES = 480;
   localparam int                   ROUND_ITEMS  = 30;
   localparam int                   FRAME_SIZE   = MAX_WIDTH * MAX_HEIGHT;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   req_type               req_data = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // frame model and register copies
   logic [PIX_W-1:0] frame_image [0:FRAME_SIZE-1];
   bit               pixel_known [0:FRAME_SIZE-1];
   logic [PIX_W-1:0] bright_threshold;
   logic [PIX_W-1:0] keep_percent;
   logic [RAD_W-1:0] window_half;
   logic [CNT_W-1:0] spot_limit;
   logic [BG_W-1:0]  background_fx;
   logic [DIM_W-1:0] frame_cols;
   logic [DIM_W-1:0] frame_rows;

   rsp_type pending_frame_results [$];
   int      fail_count = 0;
   int      cycle_count = 0;
   int      idle_pct = 0;

   bright_spot_window_reducer_core uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int active_width();
      return (int'(frame_cols) > MAX_WIDTH) ? MAX_WIDTH : int'(frame_cols);
   endfunction

   function automatic int active_height();
      return (int'(frame_rows) > MAX_HEIGHT) ? MAX_HEIGHT : int'(frame_rows);
   endfunction

   function automatic int window_radius();
      return (int'(window_half) > MAX_RADIUS) ? MAX_RADIUS : int'(window_half);
   endfunction

   // (p - bg) * level / 100 + bg with bg in 8.8, truncated and clamped
   function automatic logic [PIX_W-1:0] fade_toward_background(input logic [PIX_W-1:0] p);
      longint pv, lv, bv, num, q;
      pv = longint'(p);
      lv = longint'(keep_percent);
      bv = longint'(background_fx);
      num = (pv * 256 - bv) * lv + bv * 100;
      if (num <= 0)
         return '0;
      q = num / 25600;
      if (q > 255)
         q = 255;
      return q[PIX_W-1:0];
   endfunction

   function automatic rsp_type process_frame_command(input req_type item);
      rsp_type res;
      int      w, h, r, x, y, dx, dy, tally, a;
      bit      in_image;
      w = active_width();
      h = active_height();
      r = window_radius();
      res = '0;
      in_image = (int'(item.col) < w) && (int'(item.row) < h);
      a = int'(item.row) * MAX_WIDTH + int'(item.col);
      case (item.operation)
         OP_WRITE: begin
            if (in_image) begin
               frame_image[a] = item.pixel_in;
               pixel_known[a] = 1'b1;
            end
         end
         OP_READ: begin
            if (in_image)
               res.pixel_out = frame_image[a];
         end
         OP_REDUCE: begin
            tally = 0;
            for (dy = -r; dy <= r; dy++) begin
               y = int'(item.row) + dy;
               for (dx = -r; dx <= r; dx++) begin
                  x = int'(item.col) + dx;
                  if (y >= 0 && y < h && x >= 0 && x < w)
                     if (frame_image[y * MAX_WIDTH + x] >= bright_threshold)
                        tally++;
               end
            end
            res.bright_count = (tally > 255) ? 8'd255 : tally[7:0];
            if (tally < int'(spot_limit)) begin
               res.reduced = 1'b1;
               for (dy = -r; dy <= r; dy++) begin
                  y = int'(item.row) + dy;
                  for (dx = -r; dx <= r; dx++) begin
                     x = int'(item.col) + dx;
                     if (y >= 0 && y < h && x >= 0 && x < w)
                        frame_image[y * MAX_WIDTH + x] =
                           fade_toward_background(frame_image[y * MAX_WIDTH + x]);
                  end
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // first in-image window pixel never written, or -1
   function automatic int first_unknown_pixel(input int col, input int row);
      int w, h, r, x, y, dx, dy;
      w = active_width();
      h = active_height();
      r = window_radius();
      for (dy = -r; dy <= r; dy++) begin
         y = row + dy;
         for (dx = -r; dx <= r; dx++) begin
            x = col + dx;
            if (y >= 0 && y < h && x >= 0 && x < w)
               if (!pixel_known[y * MAX_WIDTH + x])
                  return y * MAX_WIDTH + x;
         end
      end
      return -1;
   endfunction

   function automatic req_type make_request(input logic [1:0] op, input int col, input int row,
                                            input logic [PIX_W-1:0] pix);
      req_type item;
      item.operation = op;
      item.col = col[COL_W-1:0];
      item.row = row[ROW_W-1:0];
      item.pixel_in = pix;
      return item;
   endfunction

   function automatic req_type pick_request();
      req_type     item;
      int          ew, eh, r, span_c, span_r, sel, miss, a;
      logic [31:0] noise;
      ew = active_width();
      eh = active_height();
      r = window_radius();
      span_c = (ew < 16) ? ew : 16;
      span_r = (eh < 16) ? eh : 16;
      noise = $urandom;
      item.operation = OP_UNUSED;
      item.col = noise[7:0];
      item.row = noise[15:8];
      item.pixel_in = noise[23:16];
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
         item.operation = OP_UNUSED;
      end else if (sel < 40) begin
         item.operation = OP_WRITE;
         if ($urandom_range(0, 4) != 0) begin
            item.col = COL_W'($urandom_range(0, span_c + 1));
            item.row = ROW_W'($urandom_range(0, span_r + 1));
         end
      end else if (sel < 60) begin
         item.operation = OP_READ;
         if ($urandom_range(0, 1) != 0) begin
            item.col = COL_W'($urandom_range(0, span_c + 1));
            item.row = ROW_W'($urandom_range(0, span_r + 1));
         end
      end else begin
         item.operation = OP_REDUCE;
         if ($urandom_range(0, 9) != 0) begin
            item.col = COL_W'($urandom_range(0, span_c + r));
            item.row = ROW_W'($urandom_range(0, span_r + r));
         end
         // fill the window before any reduction can touch it
         miss = first_unknown_pixel(int'(item.col), int'(item.row));
         if (miss >= 0) begin
            item.operation = OP_WRITE;
            item.col = COL_W'(miss % MAX_WIDTH);
            item.row = ROW_W'(miss / MAX_WIDTH);
         end
      end
      if (item.operation == OP_READ && int'(item.col) < ew && int'(item.row) < eh) begin
         a = int'(item.row) * MAX_WIDTH + int'(item.col);
         if (!pixel_known[a])
            item.operation = OP_WRITE;
      end
      if (item.operation == OP_WRITE && $urandom_range(0, 1) != 0)
         item.pixel_in = PIX_W'($urandom_range(bright_threshold, 255));
      return item;
   endfunction

   function automatic logic [7:0] pick_extreme_byte();
      int sel;
      sel = $urandom_range(0, 4);
      if (sel == 0)
         return 8'd0;
      if (sel == 1)
         return 8'd255;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [DIM_W-1:0] pick_dimension(input bit keep_small);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 5)
         return '0;
      if (!keep_small && sel < 9)
         return 9'd256;
      if (!keep_small && sel < 14)
         return DIM_W'($urandom_range(257, 511));
      if (!keep_small && sel < 20)
         return DIM_W'($urandom_range(17, 255));
      return DIM_W'($urandom_range(1, 16));
   endfunction

   task automatic program_register(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SPOT_BRIGHTNESS:  bright_threshold = value[PIX_W-1:0];
         CSR_REDUCTION_LEVEL:  keep_percent = value[PIX_W-1:0];
         CSR_SPOT_RADIUS:      window_half = value[RAD_W-1:0];
         CSR_SPOT_COUNT:       spot_limit = value[CNT_W-1:0];
         CSR_BACKGROUND_LEVEL: background_fx = value[BG_W-1:0];
         CSR_IMAGE_WIDTH:      frame_cols = value[DIM_W-1:0];
         CSR_IMAGE_HEIGHT:     frame_rows = value[DIM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      start <= 1'b0;
      while (pending_frame_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_request(input req_type item);
      int          gap, sel;
      logic [31:0] junk;
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         sel = $urandom_range(0, 99);
         if (sel < 70)
            gap = $urandom_range(1, 4);
         else if (sel < 95)
            gap = $urandom_range(5, 60);
         else
            gap = $urandom_range(61, 480);
         junk = $urandom;
         @(negedge clock);
         start <= 1'b0;
         req_data <= junk[$bits(req_type)-1:0];
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      pending_frame_results.push_back(process_frame_command(item));
   endtask

   task automatic pick_settings();
      logic [15:0]      junk;
      logic [7:0]       v8;
      logic [DIM_W-1:0] cols9, rows9;
      int               sel;
      junk = 16'($urandom);
      if ($urandom_range(0, 1) != 0)
         junk = '0;
      v8 = pick_extreme_byte();
      program_register(CSR_SPOT_BRIGHTNESS, {junk[15:8], v8});
      v8 = ($urandom_range(0, 5) == 0) ? 8'd100 : pick_extreme_byte();
      program_register(CSR_REDUCTION_LEVEL, {junk[15:8], v8});
      program_register(CSR_SPOT_RADIUS, {junk[15:3], 3'($urandom_range(0, 7))});
      sel = $urandom_range(0, 9);
      v8 = (sel < 2) ? pick_extreme_byte() : 8'($urandom_range(1, 30));
      program_register(CSR_SPOT_COUNT, {junk[15:8], v8});
      sel = $urandom_range(0, 9);
      if (sel < 2)
         program_register(CSR_BACKGROUND_LEVEL, 16'h0000);
      else if (sel < 4)
         program_register(CSR_BACKGROUND_LEVEL, 16'hFFFF);
      else
         program_register(CSR_BACKGROUND_LEVEL, 16'($urandom));
      // one side of the image stays small so windows fill quickly
      cols9 = pick_dimension(1'b0);
      rows9 = pick_dimension(cols9 > 16);
      program_register(CSR_IMAGE_WIDTH, {junk[15:9], cols9});
      program_register(CSR_IMAGE_HEIGHT, {junk[15:9], rows9});
      if ($urandom_range(0, 7) == 0)
         program_register(CSR_UNUSED, 16'($urandom));
   endtask

   task automatic check_pixel_access();
      send_request(make_request(OP_WRITE, 0, 0, 8'hFF));
      send_request(make_request(OP_WRITE, 255, 255, 8'h00));
      send_request(make_request(OP_WRITE, 255, 0, 8'hA5));
      send_request(make_request(OP_WRITE, 0, 255, 8'h5A));
      send_request(make_request(OP_READ, 0, 0, 8'h00));
      send_request(make_request(OP_READ, 255, 255, 8'hFF));
      send_request(make_request(OP_READ, 255, 0, 8'h00));
      send_request(make_request(OP_READ, 0, 255, 8'h00));
   endtask

   task automatic check_unused_operation();
      send_request(make_request(OP_UNUSED, 0, 0, 8'h00));
      send_request(make_request(OP_READ, 0, 0, 8'h00));
   endtask

   task automatic check_spot_reduction();
      // single pixel window, bright count not below the limit
      wait_until_drained();
      program_register(CSR_SPOT_RADIUS, 16'd0);
      program_register(CSR_SPOT_COUNT, 16'd1);
      program_register(CSR_SPOT_BRIGHTNESS, 16'd255);
      send_request(make_request(OP_REDUCE, 0, 0, 8'h00));
      // level above 100 amplifies and clamps high
      wait_until_drained();
      program_register(CSR_SPOT_COUNT, 16'd255);
      program_register(CSR_REDUCTION_LEVEL, 16'd255);
      program_register(CSR_BACKGROUND_LEVEL, 16'd25600);
      send_request(make_request(OP_REDUCE, 255, 0, 8'h00));
      send_request(make_request(OP_READ, 255, 0, 8'h00));
      // level zero pulls to the largest background
      wait_until_drained();
      program_register(CSR_REDUCTION_LEVEL, 16'd0);
      program_register(CSR_BACKGROUND_LEVEL, 16'hFFFF);
      program_register(CSR_SPOT_BRIGHTNESS, 16'd0);
      send_request(make_request(OP_REDUCE, 255, 255, 8'h00));
      send_request(make_request(OP_READ, 255, 255, 8'h00));
      // largest radius clipped by a one pixel image, centre outside too
      wait_until_drained();
      program_register(CSR_SPOT_RADIUS, 16'd7);
      program_register(CSR_IMAGE_WIDTH, 16'd1);
      program_register(CSR_IMAGE_HEIGHT, 16'd1);
      program_register(CSR_SPOT_COUNT, 16'd0);
      send_request(make_request(OP_REDUCE, 0, 0, 8'h00));
      send_request(make_request(OP_REDUCE, 200, 200, 8'h00));
   endtask

   task automatic check_image_bounds();
      send_request(make_request(OP_READ, 5, 0, 8'h00));
      send_request(make_request(OP_WRITE, 0, 3, 8'h3C));
      send_request(make_request(OP_READ, 0, 0, 8'h00));
      // zero width: nothing inside the image
      wait_until_drained();
      program_register(CSR_IMAGE_WIDTH, 16'd0);
      program_register(CSR_SPOT_COUNT, 16'd6);
      send_request(make_request(OP_WRITE, 0, 0, 8'h11));
      send_request(make_request(OP_READ, 0, 0, 8'h00));
      send_request(make_request(OP_REDUCE, 0, 0, 8'h00));
      // oversized sizes fall back to the full frame
      wait_until_drained();
      program_register(CSR_IMAGE_WIDTH, 16'h01FF);
      program_register(CSR_IMAGE_HEIGHT, 16'd300);
      program_register(CSR_UNUSED, 16'hFFFF);
      send_request(make_request(OP_READ, 255, 255, 8'h00));
   endtask

   task automatic check_random_traffic(input int pct, input int rounds);
      idle_pct = pct;
      repeat (rounds) begin
         wait_until_drained();
         pick_settings();
         repeat (ROUND_ITEMS) send_request(pick_request());
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_frame_results.size() == 0) begin
            $display("%0t: unexpected transfer pixel_out %0d reduced %0d bright_count %0d",
                     $time, rsp_data.pixel_out, rsp_data.reduced, rsp_data.bright_count);
            fail_count++;
         end else begin
            want = pending_frame_results.pop_front();
            if (rsp_data.pixel_out !== want.pixel_out) begin
               $display("%0t: pixel_out expected %0d actual %0d",
                        $time, want.pixel_out, rsp_data.pixel_out);
               fail_count++;
            end
            if (rsp_data.reduced !== want.reduced) begin
               $display("%0t: reduced expected %0d actual %0d",
                        $time, want.reduced, rsp_data.reduced);
               fail_count++;
            end
            if (rsp_data.bright_count !== want.bright_count) begin
               $display("%0t: bright_count expected %0d actual %0d",
                        $time, want.bright_count, rsp_data.bright_count);
               fail_count++;
            end
         end
      end
   end

   initial begin
      bright_threshold = RST_SPOT_BRIGHTNESS;
      keep_percent = RST_REDUCTION_LEVEL;
      window_half = RST_SPOT_RADIUS;
      spot_limit = RST_SPOT_COUNT;
      background_fx = RST_BACKGROUND_LEVEL;
      frame_cols = RST_IMAGE_WIDTH;
      frame_rows = RST_IMAGE_HEIGHT;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      check_pixel_access();
      check_unused_operation();
      check_spot_reduction();
      check_image_bounds();
      check_random_traffic(0, 6);
      check_random_traffic(66, 6);
      check_random_traffic(30, 6);
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/bswr_pkg.sv
hw/rtl/bswr_frame_ram.sv
hw/rtl/bswr_pixel_calc.sv
hw/rtl/bright_spot_window_reducer_core.sv
bench/bright_spot_window_reducer_core_test.sv
